/* src/base64_strict_decoder_assert.svh */
// ----------------------------------------------------------------------------
// base64_strict_decoder_assert.svh - assertion macros
// Shorthand for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STRICT_DECODER_ASSERT_SVH
`define BASE64_STRICT_DECODER_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset
`define B64SD_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("b64sd check failed");

// Check that a consequent holds whenever the antecedent holds
`define B64SD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64sd implication failed");

`endif

/* src/b64sd_pkg.sv */
// ----------------------------------------------------------------------------
// b64sd_pkg - shared types for the strict base64 decoder
// Item kinds, the job record between front and back, queue sizing and the
// alphabet lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64sd_pkg;

	localparam int QDepth = 4;
	localparam int QAddrW = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [23:0] MaxOutReset = 24'd10485760;
	localparam logic [7:0]  PadChar     = 8'd61;
	localparam logic [6:0]  SextetNone  = 7'd64;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_END  = 1'b1
	} item_kind_t;

	// One unit of work for the back end: a group of 1..3 bytes or a status
	typedef struct packed {
		logic        is_final;
		logic        accepted;
		logic [1:0]  count;
		logic [23:0] data;
	} job_t;

	// Map a character to its sextet; SextetNone when outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [6:0] v;
		v = SextetNone;
		if (ch >= 8'd65 && ch <= 8'd90) begin
			v = 7'(ch - 8'd65);
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			v = 7'(ch - 8'd97 + 8'd26);
		end else if (ch >= 8'd48 && ch <= 8'd57) begin
			v = 7'(ch - 8'd48 + 8'd52);
		end else if (ch == 8'd43) begin
			v = 7'd62;
		end else if (ch == 8'd47) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage

/* src/b64sd_if.sv */
// ----------------------------------------------------------------------------
// b64sd_if - channel interfaces
// Character input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface b64sd_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source (output valid, output kind, output char_code, input ready);
	modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface b64sd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       is_final;
	logic       accepted;

	modport source (output valid, output byte_value, output is_final, output accepted,
		input ready);
	modport sink (input valid, input byte_value, input is_final, input accepted,
		output ready);
endinterface

/* src/b64sd_front.sv */
// ----------------------------------------------------------------------------
// b64sd_front - character intake and validation
// Accepts one item per cycle while the job queue has room, tracks group and
// padding state, and makes each completed group or end item a back-end job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sd_front
	import b64sd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [23:0]   cfg_wdata,
	b64sd_char_if.sink    chars,
	input  logic          q_full,
	output logic          push,
	output job_t          push_job
);

	logic [23:0] max_q;
	logic [17:0] store_q, store_d;
	logic [1:0]  pos_q, pos_d;
	logic        third_pad_q, third_pad_d;
	logic        pad_group_q, pad_group_d;
	logic        any_char_q, any_char_d;
	logic        err_q, err_d;
	logic [24:0] emitted_q, emitted_d;
	logic        accept;

	assign chars.ready = !q_full;
	assign accept      = chars.valid && chars.ready;

	// Hold the output limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MaxOutReset;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Decide the next string state and the job for this item
	always_comb begin
		logic [6:0]  val;
		logic        is_pad;
		logic        bad;
		logic [1:0]  cnt;
		logic [5:0]  d;
		logic [24:0] total;
		logic [5:0]  a, b, c;
		store_d     = store_q;
		pos_d       = pos_q;
		third_pad_d = third_pad_q;
		pad_group_d = pad_group_q;
		any_char_d  = any_char_q;
		err_d       = err_q;
		emitted_d   = emitted_q;
		push        = 1'b0;
		push_job    = '0;
		val         = sextet_of(chars.char_code);
		is_pad      = (chars.char_code == PadChar);
		bad         = 1'b0;
		cnt         = 2'd3;
		d           = val[5:0];
		if (is_pad) begin
			d   = 6'd0;
			cnt = third_pad_q ? 2'd1 : 2'd2;
		end else begin
			bad = val[6] || third_pad_q;
		end
		total = emitted_q + 25'(cnt);
		a     = store_q[17:12];
		b     = store_q[11:6];
		c     = store_q[5:0];
		if (accept) begin
			if (item_kind_t'(chars.kind) == KIND_END) begin
				// Report status and clear for the next string
				push              = 1'b1;
				push_job.is_final = 1'b1;
				push_job.accepted = !err_q && any_char_q && (pos_q == 2'd0);
				push_job.count    = 2'd1;
				store_d     = '0;
				pos_d       = '0;
				third_pad_d = 1'b0;
				pad_group_d = 1'b0;
				any_char_d  = 1'b0;
				err_d       = 1'b0;
				emitted_d   = '0;
			end else begin
				any_char_d = 1'b1;
				if (err_q) begin
					// drop characters after an error
				end else if (pad_group_q) begin
					err_d = 1'b1;
				end else if (pos_q != 2'd3) begin
					if (is_pad && pos_q == 2'd2) begin
						third_pad_d = 1'b1;
						store_d     = {store_q[11:0], 6'd0};
						pos_d       = pos_q + 2'd1;
					end else if (val[6]) begin
						err_d = 1'b1;
					end else begin
						store_d = {store_q[11:0], val[5:0]};
						pos_d   = pos_q + 2'd1;
					end
				end else if (bad || total > {1'b0, max_q}) begin
					err_d = 1'b1;
				end else begin
					// Complete the group and hand its bytes on
					push           = 1'b1;
					push_job.count = cnt;
					push_job.data  = {a, b, c, d};
					emitted_d      = total;
					pad_group_d    = pad_group_q || is_pad;
					store_d        = '0;
					pos_d          = '0;
					third_pad_d    = 1'b0;
				end
			end
		end
	end

	// Advance the string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q     <= '0;
			pos_q       <= '0;
			third_pad_q <= 1'b0;
			pad_group_q <= 1'b0;
			any_char_q  <= 1'b0;
			err_q       <= 1'b0;
			emitted_q   <= '0;
		end else begin
			store_q     <= store_d;
			pos_q       <= pos_d;
			third_pad_q <= third_pad_d;
			pad_group_q <= pad_group_d;
			any_char_q  <= any_char_d;
			err_q       <= err_d;
			emitted_q   <= emitted_d;
		end
	end

endmodule

/* src/b64sd_queue.sv */
// ----------------------------------------------------------------------------
// b64sd_queue - job queue between front and back
// Small register FIFO so intake and result delivery stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "base64_strict_decoder_assert.svh"

module b64sd_queue
	import b64sd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  job_t  push_job,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output job_t  head
);

	job_t              slots_q [QDepth];
	logic [QAddrW-1:0] wr_ptr_q;
	logic [QAddrW-1:0] rd_ptr_q;
	logic [QCntW-1:0]  count_q;

	assign full      = (count_q == QCntW'(QDepth));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAddrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAddrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	`B64SD_ASSERT_IMPLY(a_no_push_when_full, push, !full)
	`B64SD_ASSERT_IMPLY(a_no_pop_when_empty, pop, not_empty)
	`B64SD_ASSERT(a_count_in_range, count_q <= QCntW'(QDepth))

endmodule

/* src/b64sd_back.sv */
// ----------------------------------------------------------------------------
// b64sd_back - result delivery
// Walks the head job byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sd_back
	import b64sd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  job_t            head,
	output logic            pop,
	b64sd_result_if.source  results
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_final_q;
	logic       out_acc_q;
	logic       load_en;
	logic       take;
	logic       last;
	logic [7:0] sel_byte;

	assign load_en = !out_valid_q || results.ready;
	assign take    = load_en && not_empty;
	assign last    = (idx_q == head.count - 2'd1);
	assign pop     = take && last;

	// Select the byte of the head job at the current index, or zero for a status job
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.data[23:16];
			2'd1:    sel_byte = head.data[15:8];
			2'd2:    sel_byte = head.data[7:0];
			default: sel_byte = 8'd0;
		endcase
		if (head.is_final) begin
			sel_byte = 8'd0;
		end
	end

	// Step through the bytes of the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (load_en) begin
				out_valid_q <= not_empty;
			end
		end
	end

	// Load the output item
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q  <= sel_byte;
			out_final_q <= head.is_final;
			out_acc_q   <= head.is_final && head.accepted;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.byte_value = out_byte_q;
	assign results.is_final   = out_final_q;
	assign results.accepted   = out_acc_q;

endmodule

/* src/base64_strict_decoder.sv */
// ----------------------------------------------------------------------------
// base64_strict_decoder - strict base64 decoder, one character per item
// Top level: intake and validation, job queue, byte delivery.
// ----------------------------------------------------------------------------
// The decoder takes one character item per clock and answers each complete
// group of four with one to three byte items, one per ready clock, and each
// end item with a single status item (is_final = 1, accepted = verdict).
// Validation and group assembly finish in the cycle an item is accepted, so
// intake runs at one item per cycle; the four-entry job queue lets intake go
// on while bytes wait on the result side, and intake stalls only when that
// queue is full. Results pass the job queue and the output register. On a
// rejected string the bytes already sent are to be discarded by the
// consumer. The user is to write max_output_bytes through cfg_we/cfg_wdata
// only while the decoder is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_strict_decoder
	import b64sd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [23:0]     cfg_wdata,
	b64sd_char_if.sink      chars,
	b64sd_result_if.source  results
);

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic not_empty;
	job_t head;

	b64sd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	b64sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	b64sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.results   (results)
	);

endmodule

/* verif/base64_strict_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_strict_decoder_test - self-checking bench for the strict decoder
// Feeds directed and random base64 strings through the character channel.
// Random strings are mostly well-formed, with some corrupted, cut short,
// overrun or pure noise. A built-in predictor keeps its own copy of the
// decode state and of max_output_bytes, and queues the byte and status
// items that each accepted character or end item should produce. The
// monitor compares every result item against the oldest queued one. Both
// channels idle at random, and one long hold on the result side backs the
// decoder up into its input. The byte limit is rewritten between phases.
// ----------------------------------------------------------------------------

module base64_strict_decoder_test;
	import b64sd_pkg::*;

	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles  = 80;
	localparam int PhaseItems  = 8;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] char_code;
	} char_item_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_final;
		logic       accepted;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;

	// Local copies of what the bench drives into the channels
	logic        src_valid = 1'b0;
	item_kind_t  src_kind = KIND_CHAR;
	logic [7:0]  src_char = '0;
	logic        sink_ready = 1'b0;
	logic        sink_hold = 1'b0;

	int src_gap = 0;
	int sink_gap = 0;
	int idle_pct = 15;
	int pushed_cnt = 0;
	int taken_cnt = 0;
	int fail_cnt = 0;
	int stall_cnt = 0;
	logic squeeze_go = 1'b0;

	char_item_t char_q[$];
	char_item_t next_item;
	decoded_t   decoded_q[$];
	decoded_t   want;
	logic [7:0] text_buf[$];

	// Predictor state for the string in progress
	logic [23:0] max_out = MaxOutReset;
	logic [17:0] sx_acc = '0;
	logic [1:0]  grp_pos = '0;
	logic        pad3 = 1'b0;
	logic        pad_done = 1'b0;
	logic        got_char = 1'b0;
	logic        bad = 1'b0;
	logic [24:0] out_count = '0;

	b64sd_char_if   chars_ch ();
	b64sd_result_if res_ch ();

	assign chars_ch.valid     = src_valid;
	assign chars_ch.kind      = src_kind;
	assign chars_ch.char_code = src_char;
	assign res_ch.ready       = sink_ready;

	base64_strict_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars_ch),
		.results   (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Map a character to its position in the alphabet; bit 6 set when outside it
	function automatic logic [6:0] alphabet_index(input logic [7:0] ch);
		if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
		if (ch >= "a" && ch <= "z") return 7'(ch - "a") + 7'd26;
		if (ch >= "0" && ch <= "9") return 7'(ch - "0") + 7'd52;
		if (ch == "+") return 7'd62;
		if (ch == "/") return 7'd63;
		return 7'd64;
	endfunction

	function automatic logic [7:0] rand_b64_char();
		int idx;
		idx = $urandom_range(0, 63);
		if (idx < 26) return 8'("A" + idx);
		if (idx < 52) return 8'("a" + idx - 26);
		if (idx < 62) return 8'("0" + idx - 52);
		return (idx == 62) ? 8'("+") : 8'("/");
	endfunction

	task automatic queue_result(input logic [7:0] v, input logic fin, input logic acc);
		decoded_t r;
		r.byte_value = v;
		r.is_final   = fin;
		r.accepted   = acc;
		decoded_q = {decoded_q, r};
	endtask

	// Advance the predictor by one accepted item and queue what it yields
	task automatic decode_char(input item_kind_t kind, input logic [7:0] ch);
		logic [6:0] sx;
		logic       is_pad;
		int         nbytes;
		logic [5:0] a, b, c, d;
		if (kind == KIND_END) begin
			queue_result(8'h00, 1'b1, !bad && got_char && grp_pos == 2'd0);
			sx_acc    = '0;
			grp_pos   = '0;
			pad3      = 1'b0;
			pad_done  = 1'b0;
			got_char  = 1'b0;
			bad       = 1'b0;
			out_count = '0;
		end else begin
			got_char = 1'b1;
			if (bad) begin
				// drop everything until the end item
			end else if (pad_done) begin
				bad = 1'b1;
			end else begin
				is_pad = (ch == PadChar);
				sx = alphabet_index(ch);
				if (grp_pos != 2'd3) begin
					if (is_pad && grp_pos == 2'd2) begin
						pad3 = 1'b1;
						sx = '0;
					end
					if (sx[6]) begin
						bad = 1'b1;
					end else begin
						sx_acc = {sx_acc[11:0], sx[5:0]};
						grp_pos = grp_pos + 2'd1;
					end
				end else begin
					d = '0;
					if (is_pad) begin
						nbytes = pad3 ? 1 : 2;
					end else if (sx[6] || pad3) begin
						nbytes = 0;
					end else begin
						d = sx[5:0];
						nbytes = 3;
					end
					if (nbytes == 0 || int'(out_count) + nbytes > int'(max_out)) begin
						bad = 1'b1;
					end else begin
						a = sx_acc[17:12];
						b = sx_acc[11:6];
						c = sx_acc[5:0];
						queue_result({a, b[5:4]}, 1'b0, 1'b0);
						if (nbytes >= 2) queue_result({b[3:0], c[5:2]}, 1'b0, 1'b0);
						if (nbytes == 3) queue_result({c[1:0], d}, 1'b0, 1'b0);
						out_count = out_count + 25'(nbytes);
						pad_done  = is_pad;
						sx_acc    = '0;
						grp_pos   = '0;
						pad3      = 1'b0;
					end
				end
			end
		end
	endtask

	task automatic push_item(input item_kind_t kind, input logic [7:0] ch);
		char_item_t it;
		it.kind = kind;
		it.char_code = ch;
		char_q = {char_q, it};
		pushed_cnt++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) push_item(KIND_CHAR, s[i]);
	endtask

	// Fill the text buffer with whole groups, padding the last one
	task automatic fill_groups(input int ngroups, input int npad);
		text_buf.delete();
		for (int i = 0; i < 4 * ngroups; i++) text_buf = {text_buf, rand_b64_char()};
		if (npad >= 1) text_buf[text_buf.size() - 1] = "=";
		if (npad >= 2) text_buf[text_buf.size() - 2] = "=";
	endtask

	task automatic push_buffered_string();
		foreach (text_buf[i]) push_item(KIND_CHAR, text_buf[i]);
		push_item(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// Build one random string: mostly well-formed, the rest damaged or noise
	task automatic send_random_string();
		int mode;
		int len;
		int sel;
		mode = $urandom_range(0, 9);
		fill_groups($urandom_range(1, 4), $urandom_range(0, 2));
		case (mode)
			6: begin
				text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
			end
			7: begin
				len = $urandom_range(1, 3);
				repeat (len) void'(text_buf.pop_back());
			end
			8: begin
				len = $urandom_range(1, 4);
				repeat (len) text_buf = {text_buf, ($urandom_range(0, 3) == 0) ? 8'("=") :
					rand_b64_char()};
			end
			9: begin
				text_buf.delete();
				len = $urandom_range(0, 9);
				repeat (len) begin
					sel = $urandom_range(0, 2);
					if (sel == 0) text_buf = {text_buf, 8'($urandom_range(0, 255))};
					else if (sel == 1) text_buf = {text_buf, 8'("=")};
					else text_buf = {text_buf, rand_b64_char()};
				end
			end
			default: begin
				// keep the well-formed string
			end
		endcase
		push_buffered_string();
	endtask

	// Hold until every item is taken and every result has come back
	task automatic wait_idle();
		while (taken_cnt != pushed_cnt || decoded_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_max(input logic [23:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_out = v;
	endtask

	// Drive character items from the pending queue, with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (src_valid && chars_ch.ready) begin
				decode_char(src_kind, src_char);
				taken_cnt++;
			end
			if (!src_valid || chars_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (char_q.size() > 0) begin
					next_item = char_q[0];
					char_q.delete(0);
					src_valid <= 1'b1;
					src_kind  <= next_item.kind;
					src_char  <= next_item.char_code;
					if ($urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 16);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result item against the oldest prediction; pace ready
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (res_ch.valid && sink_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: byte_value %0h is_final %0b accepted %0b",
						res_ch.byte_value, res_ch.is_final, res_ch.accepted);
					fail_cnt++;
				end else begin
					want = decoded_q[0];
					decoded_q.delete(0);
					if (res_ch.byte_value !== want.byte_value) begin
						$error("byte_value: expected %0h, got %0h", want.byte_value,
							res_ch.byte_value);
						fail_cnt++;
					end
					if (res_ch.is_final !== want.is_final) begin
						$error("is_final: expected %0b, got %0b", want.is_final, res_ch.is_final);
						fail_cnt++;
					end
					if (res_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0b, got %0b", want.accepted, res_ch.accepted);
						fail_cnt++;
					end
				end
			end
			if (sink_hold) begin
				sink_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= 1'b1;
				if ($urandom_range(0, 99) < idle_pct) sink_gap = $urandom_range(1, 16);
			end
		end
	end

	// Hold off the result side for a long stretch once the squeeze starts
	initial begin
		wait (squeeze_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (src_valid && chars_ch.ready) || (res_ch.valid && sink_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= StallLimit) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// Reset, directed strings, then random phases with different byte limits
	initial begin
		int goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// full group, then a two-byte group followed by a stray character
		push_str("TWFu");
		push_item(KIND_END, 8'h00);
		push_str("TWE=/");
		push_item(KIND_END, 8'hFF);
		// pad in second place; the extreme byte after it is ignored
		push_str("Q=");
		push_item(KIND_CHAR, 8'hFF);
		push_item(KIND_END, 8'h00);
		// byte outside the alphabet in first place
		push_item(KIND_CHAR, 8'h00);
		push_item(KIND_END, 8'h00);
		// data after a third-place pad
		push_str("TQ=A");
		push_item(KIND_END, 8'h00);
		// empty string, then a partial group
		push_item(KIND_END, 8'h00);
		push_str("zz");
		push_item(KIND_END, 8'h00);

		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			case (phase)
				0: idle_pct = 20;
				1: begin
					write_max(24'd0);
					idle_pct = 0;
				end
				2: begin
					write_max(24'hFFFFFF);
					idle_pct = 25;
				end
				3: begin
					write_max(24'($urandom_range(1, 8)));
					idle_pct = 10;
				end
				default: begin
					write_max(MaxOutReset);
					idle_pct = 0;
				end
			endcase
			if (phase == 2) begin
				// back the decoder up with a long valid string
				squeeze_go = 1'b1;
				fill_groups(8, 0);
				push_buffered_string();
			end
			goal = pushed_cnt + PhaseItems;
			while (pushed_cnt < goal) send_random_string();
		end

		wait_idle();
		@(negedge clk);
		if (fail_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/b64sd_pkg.sv
src/b64sd_if.sv
src/b64sd_front.sv
src/b64sd_queue.sv
src/b64sd_back.sv
src/base64_strict_decoder.sv
verif/base64_strict_decoder_test.sv
